### hdl/euler_angles_to_rigid_transform_core_assert.svh
// assertion macros for the euler angle transform core
// needs clk and arst_n in the scope of each use
`ifndef EULER_ANGLES_TO_RIGID_TRANSFORM_CORE_ASSERT_SVH
`define EULER_ANGLES_TO_RIGID_TRANSFORM_CORE_ASSERT_SVH
// same-cycle implication
`define EATR_ASSERT_IMPLY(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("eatr: same-cycle check failed");
// next-cycle implication
`define EATR_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("eatr: next-cycle check failed");
`endif

### hdl/eatr_pkg.sv
// shared types, constants and fixed-point helpers for the euler angle core
// no dependencies
package eatr_pkg;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int ROT_FRAC_BITS = 14;
	localparam int ANGLE_W = 16;
	localparam int SHIFT_W = 32;
	localparam int ROT_W = 16;
	localparam int TURN = 360 << ANGLE_FRAC_BITS;
	localparam int EIGHTH = 45 << ANGLE_FRAC_BITS;
	localparam int HALF_ROUND = (180 << ANGLE_FRAC_BITS) / 2;
	localparam int U_W = $clog2(EIGHTH + 1);
	localparam int AMOD_W = $clog2(TURN);
	localparam int PI_W = 33;
	localparam logic [PI_W-1:0] PI_Q31 = 33'd6746518852;
	localparam int PRE_SH = ANGLE_FRAC_BITS + 2;
	localparam int RAD_W = U_W + PI_W;
	localparam int VS_W = RAD_W - PRE_SH;
	localparam logic [31:0] M45 = 32'((80'd1 << VS_W) / 45);
	localparam int N_TERMS = 7;
	localparam int SC_LAT = 4 + 3 * N_TERMS + 1;
	localparam int BK_LAT = SC_LAT + 3;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int SUM_W = 35;
	localparam int OUT_SH = 31 - ROT_FRAC_BITS;
	localparam int ROT_ONE = 1 << ROT_FRAC_BITS;
	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

	localparam int DIV_S [N_TERMS] = '{6, 20, 42, 72, 110, 156, 210};
	localparam int DIV_C [N_TERMS] = '{2, 12, 30, 56, 90, 132, 182};
	localparam logic [31:0] RCP_S [N_TERMS] = '{
		32'((64'd1 << 32) / 6), 32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 42),
		32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 156),
		32'((64'd1 << 32) / 210)};
	localparam logic [31:0] RCP_C [N_TERMS] = '{
		32'((64'd1 << 32) / 2), 32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 30),
		32'((64'd1 << 32) / 56), 32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 132),
		32'((64'd1 << 32) / 182)};

	typedef logic [31:0] mag_t;
	typedef logic signed [33:0] q31_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic [2:0] k;
		logic [U_W-1:0] u;
	} ang_t;

	typedef struct packed {
		ang_t roll;
		ang_t pitch;
		ang_t yaw;
		logic signed [SHIFT_W-1:0] sx;
		logic signed [SHIFT_W-1:0] sy;
		logic signed [SHIFT_W-1:0] sz;
	} pose_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic mag_t umul31(input mag_t a, input mag_t b);
		logic [63:0] p;
		p = 64'(a) * 64'(b) + (64'd1 << 30);
		return p[62:31];
	endfunction

	function automatic q31_t smul31(input q31_t a, input q31_t b);
		logic neg;
		logic [33:0] ua;
		logic [33:0] ub;
		logic [67:0] p;
		q31_t m;
		neg = a[33] ^ b[33];
		ua = a[33] ? 34'(-a) : 34'(a);
		ub = b[33] ? 34'(-b) : 34'(b);
		p = 68'(ua) * 68'(ub) + (68'd1 << 30);
		m = q31_t'(p[64:31]);
		return neg ? -m : m;
	endfunction

	function automatic logic signed [ROT_W-1:0] to_out(input sum_t v);
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] m;
		mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
		m = (mag + (SUM_W'(1) << (OUT_SH - 1))) >> OUT_SH;
		if (m > SUM_W'(ROT_ONE)) m = SUM_W'(ROT_ONE);
		return v[SUM_W-1] ? -$signed(ROT_W'(m)) : $signed(ROT_W'(m));
	endfunction
endpackage

### hdl/euler_angles_to_rigid_transform_core.sv
// top level of the euler angle to rigid transform core
// depends on eatr_pkg, eatr_front, eatr_back and the assertion macro header
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   in      | in_valid/in_stall  | roll/pitch/yaw_angle, shift_x/y/z
//   out     | out_valid/out_stall| r00..r22, out_shift_x/y/z
//
// one request per cycle sustained while the output is not stalled; each request
// passes through the 26-stage sine/cosine pipeline, two product stages, the sum
// stage and the output register
// the front queue holds four requests and stalls the input only when full
// a stalled output freezes the whole back pipeline; reset clears queue and valids
`include "euler_angles_to_rigid_transform_core_assert.svh"
module euler_angles_to_rigid_transform_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [eatr_pkg::ANGLE_W-1:0] roll_angle,
	input  logic signed [eatr_pkg::ANGLE_W-1:0] pitch_angle,
	input  logic signed [eatr_pkg::ANGLE_W-1:0] yaw_angle,
	input  logic signed [eatr_pkg::SHIFT_W-1:0] shift_x,
	input  logic signed [eatr_pkg::SHIFT_W-1:0] shift_y,
	input  logic signed [eatr_pkg::SHIFT_W-1:0] shift_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [eatr_pkg::ROT_W-1:0] r00,
	output logic signed [eatr_pkg::ROT_W-1:0] r01,
	output logic signed [eatr_pkg::ROT_W-1:0] r02,
	output logic signed [eatr_pkg::ROT_W-1:0] r10,
	output logic signed [eatr_pkg::ROT_W-1:0] r11,
	output logic signed [eatr_pkg::ROT_W-1:0] r12,
	output logic signed [eatr_pkg::ROT_W-1:0] r20,
	output logic signed [eatr_pkg::ROT_W-1:0] r21,
	output logic signed [eatr_pkg::ROT_W-1:0] r22,
	output logic signed [eatr_pkg::SHIFT_W-1:0] out_shift_x,
	output logic signed [eatr_pkg::SHIFT_W-1:0] out_shift_y,
	output logic signed [eatr_pkg::SHIFT_W-1:0] out_shift_z
);
	import eatr_pkg::*;

	pose_t head;
	q_stat_t q_stat;
	logic pop;
	logic signed [ROT_W-1:0] rot [9];

	eatr_front u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.roll_angle, .pitch_angle, .yaw_angle, .shift_x, .shift_y, .shift_z,
		.pop, .head, .q_stat
	);

	eatr_back u_back (
		.clk, .arst_n, .head, .q_stat, .pop, .out_valid, .out_stall, .rot,
		.sh_x(out_shift_x), .sh_y(out_shift_y), .sh_z(out_shift_z)
	);

	assign r00 = rot[0];
	assign r01 = rot[1];
	assign r02 = rot[2];
	assign r10 = rot[3];
	assign r11 = rot[4];
	assign r12 = rot[5];
	assign r20 = rot[6];
	assign r21 = rot[7];
	assign r22 = rot[8];

	`EATR_ASSERT_NEXT(a_push_fills, in_valid && !in_stall, !q_stat.empty)
	`EATR_ASSERT_IMPLY(a_pop_nonempty, pop, !q_stat.empty)
	`EATR_ASSERT_IMPLY(a_full_stalls, q_stat.full, in_stall)
endmodule

### hdl/eatr_front.sv
// front end: angle reduction to octant and offset, request queue
// depends on eatr_pkg
module eatr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [eatr_pkg::ANGLE_W-1:0] roll_angle,
	input  logic signed [eatr_pkg::ANGLE_W-1:0] pitch_angle,
	input  logic signed [eatr_pkg::ANGLE_W-1:0] yaw_angle,
	input  logic signed [eatr_pkg::SHIFT_W-1:0] shift_x,
	input  logic signed [eatr_pkg::SHIFT_W-1:0] shift_y,
	input  logic signed [eatr_pkg::SHIFT_W-1:0] shift_z,
	input  logic pop,
	output eatr_pkg::pose_t head,
	output eatr_pkg::q_stat_t q_stat
);
	import eatr_pkg::*;

	function automatic ang_t classify(input logic signed [ANGLE_W-1:0] a);
		logic [AMOD_W-1:0] amod;
		logic [AMOD_W-1:0] r;
		logic [2:0] k;
		ang_t res;
		amod = a[ANGLE_W-1] ? AMOD_W'(32'(a) + TURN) : AMOD_W'(a);
		k = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (amod >= AMOD_W'(i * EIGHTH)) k = 3'(i);
		end
		r = amod - AMOD_W'(32'(k) * EIGHTH);
		res.k = k;
		res.u = k[0] ? U_W'(AMOD_W'(EIGHTH) - r) : U_W'(r);
		return res;
	endfunction

	pose_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] cnt_q;
	logic push;
	pose_t entry;

	assign in_stall = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign push = in_valid && !in_stall;
	assign head = mem_q[rd_ptr_q];
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full = in_stall;

	always_comb begin
		entry.roll = classify(roll_angle);
		entry.pitch = classify(pitch_angle);
		entry.yaw = classify(yaw_angle);
		entry.sx = shift_x;
		entry.sy = shift_y;
		entry.sz = shift_z;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

### hdl/eatr_sincos.sv
// pipelined sine and cosine of a reduced angle, eight-term series in q31
// depends on eatr_pkg
module eatr_sincos (
	input  logic clk,
	input  logic en,
	input  logic [2:0] k_in,
	input  logic [eatr_pkg::U_W-1:0] u_in,
	output eatr_pkg::q31_t sin_out,
	output eatr_pkg::q31_t cos_out
);
	import eatr_pkg::*;

	typedef struct packed {
		logic [2:0] k;
		mag_t x2;
		mag_t ts;
		mag_t tc;
		q31_t ss;
		q31_t cs;
	} term_t;

	typedef struct packed {
		logic [2:0] k;
		mag_t x2;
		mag_t ps;
		mag_t pc;
		mag_t qs;
		mag_t qc;
		q31_t ss;
		q31_t cs;
	} prod_t;

	logic [RAD_W-1:0] rad_s1;
	logic [2:0] k_s1, k_s2, k_s3;
	logic [VS_W-1:0] vs_s2;
	mag_t qa_s2;
	mag_t x_s3;
	term_t tm_s [N_TERMS+1];
	prod_t pa_s [N_TERMS];
	prod_t pb_s [N_TERMS];
	q31_t sin_s, cos_s;

	logic [VS_W-1:0] vs_c;
	logic [VS_W+31:0] vprod_c;
	logic [VS_W-1:0] rem_c;

	assign vs_c = rad_s1[RAD_W-1:PRE_SH];
	assign vprod_c = (VS_W + 32)'(vs_c) * (VS_W + 32)'(M45);
	assign rem_c = vs_s2 - VS_W'(64'(qa_s2) * 64'd45);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= RAD_W'(u_in) * RAD_W'(PI_Q31) + RAD_W'(HALF_ROUND);
			k_s1 <= k_in;
			vs_s2 <= vs_c;
			qa_s2 <= vprod_c[VS_W+31:VS_W];
			k_s2 <= k_s1;
			x_s3 <= qa_s2 + ((rem_c >= VS_W'(45)) ? 32'd1 : 32'd0);
			k_s3 <= k_s2;
			tm_s[0].k <= k_s3;
			tm_s[0].x2 <= umul31(x_s3, x_s3);
			tm_s[0].ts <= x_s3;
			tm_s[0].tc <= ONE_Q31;
			tm_s[0].ss <= $signed({2'b00, x_s3});
			tm_s[0].cs <= $signed({2'b00, ONE_Q31});
		end
	end

	for (genvar n = 0; n < N_TERMS; n++) begin : g_term
		logic [63:0] qsp, qcp;
		mag_t ts_c, tc_c;

		assign qsp = 64'(pa_s[n].ps) * 64'(RCP_S[n]);
		assign qcp = 64'(pa_s[n].pc) * 64'(RCP_C[n]);
		assign ts_c = pb_s[n].qs + (((pb_s[n].ps - 32'(64'(pb_s[n].qs) * 64'(DIV_S[n])))
			>= 32'(DIV_S[n])) ? 32'd1 : 32'd0);
		assign tc_c = pb_s[n].qc + (((pb_s[n].pc - 32'(64'(pb_s[n].qc) * 64'(DIV_C[n])))
			>= 32'(DIV_C[n])) ? 32'd1 : 32'd0);

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s[n].k <= tm_s[n].k;
				pa_s[n].x2 <= tm_s[n].x2;
				pa_s[n].ps <= umul31(tm_s[n].ts, tm_s[n].x2);
				pa_s[n].pc <= umul31(tm_s[n].tc, tm_s[n].x2);
				pa_s[n].qs <= '0;
				pa_s[n].qc <= '0;
				pa_s[n].ss <= tm_s[n].ss;
				pa_s[n].cs <= tm_s[n].cs;

				pb_s[n].k <= pa_s[n].k;
				pb_s[n].x2 <= pa_s[n].x2;
				pb_s[n].ps <= pa_s[n].ps;
				pb_s[n].pc <= pa_s[n].pc;
				pb_s[n].qs <= qsp[63:32];
				pb_s[n].qc <= qcp[63:32];
				pb_s[n].ss <= pa_s[n].ss;
				pb_s[n].cs <= pa_s[n].cs;

				tm_s[n+1].k <= pb_s[n].k;
				tm_s[n+1].x2 <= pb_s[n].x2;
				tm_s[n+1].ts <= ts_c;
				tm_s[n+1].tc <= tc_c;
				if (n % 2 == 0) begin
					tm_s[n+1].ss <= pb_s[n].ss - $signed({2'b00, ts_c});
					tm_s[n+1].cs <= pb_s[n].cs - $signed({2'b00, tc_c});
				end else begin
					tm_s[n+1].ss <= pb_s[n].ss + $signed({2'b00, ts_c});
					tm_s[n+1].cs <= pb_s[n].cs + $signed({2'b00, tc_c});
				end
			end
		end
	end

	q31_t fs_c, fc_c;
	logic [2:0] kf_c;

	always_comb begin
		kf_c = tm_s[N_TERMS].k;
		fs_c = kf_c[0] ? tm_s[N_TERMS].cs : tm_s[N_TERMS].ss;
		fc_c = kf_c[0] ? tm_s[N_TERMS].ss : tm_s[N_TERMS].cs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (kf_c[2:1])
				2'd0: begin sin_s <= fs_c; cos_s <= fc_c; end
				2'd1: begin sin_s <= fc_c; cos_s <= -fs_c; end
				2'd2: begin sin_s <= -fs_c; cos_s <= -fc_c; end
				default: begin sin_s <= -fc_c; cos_s <= fs_c; end
			endcase
		end
	end

	assign sin_out = sin_s;
	assign cos_out = cos_s;
endmodule

### hdl/eatr_back.sv
// back end: three sine/cosine pipelines, matrix products, output register
// depends on eatr_pkg and eatr_sincos
module eatr_back (
	input  logic clk,
	input  logic arst_n,
	input  eatr_pkg::pose_t head,
	input  eatr_pkg::q_stat_t q_stat,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [eatr_pkg::ROT_W-1:0] rot [9],
	output logic signed [eatr_pkg::SHIFT_W-1:0] sh_x,
	output logic signed [eatr_pkg::SHIFT_W-1:0] sh_y,
	output logic signed [eatr_pkg::SHIFT_W-1:0] sh_z
);
	import eatr_pkg::*;

	logic en;
	logic out_valid_q;
	logic [BK_LAT-1:0] vld_s;
	logic [3*SHIFT_W-1:0] sh_s [BK_LAT];
	q31_t s1, c1, s2, c2, s3, c3;

	assign en = !(out_valid_q && out_stall);
	assign pop = en && !q_stat.empty;

	eatr_sincos u_roll (.clk, .en, .k_in(head.roll.k), .u_in(head.roll.u),
		.sin_out(s1), .cos_out(c1));
	eatr_sincos u_pitch (.clk, .en, .k_in(head.pitch.k), .u_in(head.pitch.u),
		.sin_out(s2), .cos_out(c2));
	eatr_sincos u_yaw (.clk, .en, .k_in(head.yaw.k), .u_in(head.yaw.u),
		.sin_out(s3), .cos_out(c3));

	q31_t c3s2_s1, s3s2_s1, p00_s1, p10_s1, p21_s1, p22_s1;
	q31_t s3c1_s1, s3s1_s1, c3c1_s1, c3s1_s1, s2_s1, sn1_s1, cn1_s1;
	q31_t a_s2, b_s2, c_s2, d_s2;
	q31_t p00_s2, p10_s2, p21_s2, p22_s2, s3c1_s2, s3s1_s2, c3c1_s2, c3s1_s2, s2_s2;
	sum_t sum_s3 [9];
	logic signed [ROT_W-1:0] rot_q [9];
	logic [3*SHIFT_W-1:0] sh_q;

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s[0] <= {head.sx, head.sy, head.sz};
			for (int i = 1; i < BK_LAT; i++) sh_s[i] <= sh_s[i-1];

			c3s2_s1 <= smul31(c3, s2);
			s3s2_s1 <= smul31(s3, s2);
			p00_s1 <= smul31(c2, c3);
			p10_s1 <= smul31(s3, c2);
			p21_s1 <= smul31(c2, s1);
			p22_s1 <= smul31(c2, c1);
			s3c1_s1 <= smul31(s3, c1);
			s3s1_s1 <= smul31(s3, s1);
			c3c1_s1 <= smul31(c3, c1);
			c3s1_s1 <= smul31(c3, s1);
			s2_s1 <= s2;
			sn1_s1 <= s1;
			cn1_s1 <= c1;

			a_s2 <= smul31(c3s2_s1, sn1_s1);
			b_s2 <= smul31(c3s2_s1, cn1_s1);
			c_s2 <= smul31(s3s2_s1, sn1_s1);
			d_s2 <= smul31(s3s2_s1, cn1_s1);
			p00_s2 <= p00_s1;
			p10_s2 <= p10_s1;
			p21_s2 <= p21_s1;
			p22_s2 <= p22_s1;
			s3c1_s2 <= s3c1_s1;
			s3s1_s2 <= s3s1_s1;
			c3c1_s2 <= c3c1_s1;
			c3s1_s2 <= c3s1_s1;
			s2_s2 <= s2_s1;

			sum_s3[0] <= sum_t'(p00_s2);
			sum_s3[1] <= sum_t'(a_s2) - sum_t'(s3c1_s2);
			sum_s3[2] <= sum_t'(b_s2) + sum_t'(s3s1_s2);
			sum_s3[3] <= sum_t'(p10_s2);
			sum_s3[4] <= sum_t'(c_s2) + sum_t'(c3c1_s2);
			sum_s3[5] <= sum_t'(d_s2) - sum_t'(c3s1_s2);
			sum_s3[6] <= -sum_t'(s2_s2);
			sum_s3[7] <= sum_t'(p21_s2);
			sum_s3[8] <= sum_t'(p22_s2);

			for (int i = 0; i < 9; i++) rot_q[i] <= to_out(sum_s3[i]);
			sh_q <= sh_s[BK_LAT-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[BK_LAT-2:0], pop};
			out_valid_q <= vld_s[BK_LAT-1];
		end
	end

	assign out_valid = out_valid_q;
	assign rot = rot_q;
	assign sh_x = sh_q[3*SHIFT_W-1:2*SHIFT_W];
	assign sh_y = sh_q[2*SHIFT_W-1:SHIFT_W];
	assign sh_z = sh_q[SHIFT_W-1:0];
endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for euler_angles_to_rigid_transform_core
// holds a pose-to-matrix predictor and a scoreboard class; depends on eatr_pkg and the core
module tb_top;
	import eatr_pkg::*;

	typedef struct {
		logic signed [ROT_W-1:0] rot [9];
		logic signed [SHIFT_W-1:0] sx;
		logic signed [SHIFT_W-1:0] sy;
		logic signed [SHIFT_W-1:0] sz;
	} transform_t;

	function automatic longint unsigned mul_q31(input longint unsigned a, input longint unsigned b);
		return (a * b + (64'd1 << 30)) >> 31;
	endfunction

	function automatic longint mul_q31_signed(input longint a, input longint b);
		logic neg;
		longint unsigned m;
		neg = (a < 0) != (b < 0);
		m = mul_q31((a < 0) ? -a : a, (b < 0) ? -b : b);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic void angle_sin_cos(input logic [ANGLE_W-1:0] ang, output longint sv,
			output longint cv);
		longint turn, eighth, half_turn, a, k, r, u, ss, cs, fs, fc;
		longint unsigned x, x2, ts, tc;
		turn = longint'(360) << ANGLE_FRAC_BITS;
		eighth = longint'(45) << ANGLE_FRAC_BITS;
		half_turn = longint'(180) << ANGLE_FRAC_BITS;
		a = longint'($signed(ang));
		a = a % turn;
		if (a < 0) a += turn;
		k = a / eighth;
		r = a - k * eighth;
		u = k[0] ? (eighth - r) : r;
		x = (longint'(u) * 64'd6746518852 + half_turn / 2) / half_turn;
		x2 = mul_q31(x, x);
		ts = x;
		tc = 64'd2147483648;
		ss = x;
		cs = 64'd2147483648;
		for (int n = 1; n <= 7; n++) begin
			ts = mul_q31(ts, x2) / ((2 * n) * (2 * n + 1));
			tc = mul_q31(tc, x2) / ((2 * n - 1) * (2 * n));
			if (n % 2) begin
				ss -= ts;
				cs -= tc;
			end else begin
				ss += ts;
				cs += tc;
			end
		end
		if (k[0]) begin
			fs = cs;
			fc = ss;
		end else begin
			fs = ss;
			fc = cs;
		end
		case (k[2:1])
			2'd0: begin sv = fs; cv = fc; end
			2'd1: begin sv = fc; cv = -fs; end
			2'd2: begin sv = -fs; cv = -fc; end
			default: begin sv = -fc; cv = fs; end
		endcase
	endfunction

	function automatic logic signed [ROT_W-1:0] round_entry(input longint v);
		longint unsigned mag;
		longint m;
		mag = (v < 0) ? -v : v;
		m = (mag + (64'd1 << (30 - ROT_FRAC_BITS))) >> (31 - ROT_FRAC_BITS);
		if (m > (longint'(1) << ROT_FRAC_BITS)) m = longint'(1) << ROT_FRAC_BITS;
		if (v < 0) m = -m;
		if (m > 32767) m = 32767;
		if (m < -32768) m = -32768;
		return m[ROT_W-1:0];
	endfunction

	function automatic transform_t pose_to_transform(input logic [ANGLE_W-1:0] ro,
			input logic [ANGLE_W-1:0] pi, input logic [ANGLE_W-1:0] ya,
			input logic [SHIFT_W-1:0] x, input logic [SHIFT_W-1:0] y,
			input logic [SHIFT_W-1:0] z);
		transform_t t;
		longint s1, c1, s2, c2, s3, c3, c3s2, s3s2;
		angle_sin_cos(ro, s1, c1);
		angle_sin_cos(pi, s2, c2);
		angle_sin_cos(ya, s3, c3);
		c3s2 = mul_q31_signed(c3, s2);
		s3s2 = mul_q31_signed(s3, s2);
		t.rot[0] = round_entry(mul_q31_signed(c2, c3));
		t.rot[1] = round_entry(mul_q31_signed(c3s2, s1) - mul_q31_signed(s3, c1));
		t.rot[2] = round_entry(mul_q31_signed(c3s2, c1) + mul_q31_signed(s3, s1));
		t.rot[3] = round_entry(mul_q31_signed(s3, c2));
		t.rot[4] = round_entry(mul_q31_signed(s3s2, s1) + mul_q31_signed(c3, c1));
		t.rot[5] = round_entry(mul_q31_signed(s3s2, c1) - mul_q31_signed(c3, s1));
		t.rot[6] = round_entry(-s2);
		t.rot[7] = round_entry(mul_q31_signed(c2, s1));
		t.rot[8] = round_entry(mul_q31_signed(c2, c1));
		t.sx = x;
		t.sy = y;
		t.sz = z;
		return t;
	endfunction

	class transform_scoreboard;
		transform_t expected_transforms [$];
		int errors;

		function new();
			errors = 0;
		endfunction

		task report(input string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		function void note_pose(input transform_t t);
			expected_transforms.push_back(t);
		endfunction

		task check_transform(input transform_t got);
			transform_t want;
			if (expected_transforms.size() == 0) begin
				report("transform with no pending request");
			end else begin
				want = expected_transforms.pop_front();
				for (int i = 0; i < 9; i++)
					if (got.rot[i] !== want.rot[i])
						report($sformatf("r%0d%0d got %0d want %0d", i / 3, i % 3,
							got.rot[i], want.rot[i]));
				if (got.sx !== want.sx) report($sformatf("out_shift_x got %h want %h", got.sx, want.sx));
				if (got.sy !== want.sy) report($sformatf("out_shift_y got %h want %h", got.sy, want.sy));
				if (got.sz !== want.sz) report($sformatf("out_shift_z got %h want %h", got.sz, want.sz));
			end
		endtask
	endclass

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall;
	logic signed [ANGLE_W-1:0] roll_angle, pitch_angle, yaw_angle;
	logic signed [SHIFT_W-1:0] shift_x, shift_y, shift_z;
	logic signed [ROT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [SHIFT_W-1:0] out_shift_x, out_shift_y, out_shift_z;

	transform_scoreboard sb = new();
	int idle_cycles = 0;
	int stall_hold = 0;
	localparam int WATCHDOG_LIMIT = 2000;

	euler_angles_to_rigid_transform_core DUT (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		transform_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_pose(pose_to_transform(roll_angle, pitch_angle, yaw_angle,
					shift_x, shift_y, shift_z));
			if (out_valid && !out_stall) begin
				got.rot = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
				got.sx = out_shift_x;
				got.sy = out_shift_y;
				got.sz = out_shift_z;
				sb.check_transform(got);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("euler_angles_to_rigid_transform_core regression: fail");
				$finish;
			end
		end
	end

	// receiver back-pressure: calm stretches, short stalls, rare long ones
	always @(negedge clk) begin
		int r;
		if (stall_hold == 0) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				out_stall = 1'b0;
				stall_hold = $urandom_range(1, 40);
			end else if (r < 95) begin
				out_stall = 1'b1;
				stall_hold = $urandom_range(1, 3);
			end else begin
				out_stall = 1'b1;
				stall_hold = $urandom_range(20, 60);
			end
		end else begin
			stall_hold--;
		end
	end

	task automatic send_pose(input logic [ANGLE_W-1:0] ro, input logic [ANGLE_W-1:0] pi,
			input logic [ANGLE_W-1:0] ya, input logic [SHIFT_W-1:0] x,
			input logic [SHIFT_W-1:0] y, input logic [SHIFT_W-1:0] z);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		roll_angle = ro;
		pitch_angle = pi;
		yaw_angle = ya;
		shift_x = x;
		shift_y = y;
		shift_z = z;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [ANGLE_W-1:0] random_angle();
		if ($urandom_range(0, 9) < 8) return ANGLE_W'($signed($urandom_range(0, 46080)) - 23040);
		return ANGLE_W'($urandom());
	endfunction

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_transforms.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [ANGLE_W-1:0] edge_angles [16];
		edge_angles = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520, -16'sd11520,
			16'sd5760, 16'sd5761, 16'sd5759, 16'sd17280, -16'sd17280,
			16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sd23041, -16'sd23041};
		arst_n = 1'b0;
		in_valid = 1'b0;
		roll_angle = '0;
		pitch_angle = '0;
		yaw_angle = '0;
		shift_x = '0;
		shift_y = '0;
		shift_z = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 16; i++)
			send_pose(edge_angles[i], edge_angles[(i + 5) % 16], edge_angles[(i + 11) % 16],
				(i % 2) ? 32'h7fff_ffff : 32'h8000_0000, i % 3 ? 32'hffff_ffff : 32'h0,
				$urandom());
		send_pose(16'sd11520, 16'sd11520, 16'sd11520, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
		send_pose(-16'sd23040, -16'sd11520, 16'sd23040, 32'h1, 32'h8000_0000, 32'h7fff_ffff);
		drain();

		for (int i = 0; i < 1000; i++) begin
			if (i == 500) drain();
			send_pose(random_angle(), random_angle(), random_angle(),
				$urandom(), $urandom(), $urandom());
		end
		drain();
		repeat (40) @(posedge clk);

		if (sb.errors == 0 && sb.expected_transforms.size() == 0)
			$display("euler_angles_to_rigid_transform_core regression: pass");
		else
			$display("euler_angles_to_rigid_transform_core regression: fail");
		$finish;
	end
endmodule
